@@ rtl/core/spq_pkg.sv @@
// Shared defaults and request and status codes for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 8;
  localparam int KEY_BITS = 16;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_EXTRACT = 2'd1;
  localparam logic [1:0] REQ_CHANGE  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

endpackage

@@ rtl/core/sorted_priority_queue_core.sv @@
// Sorted-list max priority queue: entries kept in one RAM, largest key at address 0.
// An insert scans down from the tail to its place; extract and change pass over every entry,
// and change then inserts the new key if there is room; an empty-queue extract or change, a dropped
// insert and an unused code skip the scan. Reads are pipelined with writes.
// One request in flight; the next is taken the cycle after its result is registered.
// Synchronous reset empties the queue; RAM contents are not cleared.
module sorted_priority_queue_core #(
  parameter int CAPACITY = spq_pkg::CAPACITY,
  parameter int ID_BITS  = spq_pkg::ID_BITS,
  parameter int KEY_BITS = spq_pkg::KEY_BITS,
  localparam int EW      = ID_BITS + KEY_BITS,
  localparam int CW      = $clog2(CAPACITY + 1),
  localparam int IN_W    = ((EW + 7) / 8) * 8,
  localparam int OUT_RAW = 2 * EW + CW,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // item_id, item_key
  input  logic [1:0]       s_tuser,   // req_type
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_id, out_key, front_id, front_key, entry_count
  output logic [1:0]       m_tuser    // status
);

  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_INS,
    S_FRONT,
    S_DONE
  } state_t;

  state_t              state;
  logic [1:0]          req;
  logic [ID_BITS-1:0]  nid;
  logic [KEY_BITS-1:0] nkey;
  logic [CW-1:0]       count;
  logic [CW-1:0]       ptr;
  logic [AW-1:0]       lag;
  logic                lag_ok;
  logic                issue_ok;
  logic                found;
  logic                pend0;
  logic [1:0]          status;
  logic [ID_BITS-1:0]  xid;
  logic [KEY_BITS-1:0] xkey;

  logic                out_valid;
  logic [1:0]          out_status;
  logic [ID_BITS-1:0]  out_id;
  logic [KEY_BITS-1:0] out_key;
  logic [ID_BITS-1:0]  front_id;
  logic [KEY_BITS-1:0] front_key;
  logic [CW-1:0]       entry_count;

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [EW-1:0]       ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [EW-1:0]       ram_q;

  logic [ID_BITS-1:0]  d_id;
  logic [KEY_BITS-1:0] d_key;
  logic                rem_match;
  logic                ins_shift;
  logic [CW-1:0]       ins_n;
  logic                out_free;

  // entry word: key in the low bits, id above
  assign d_key = ram_q[KEY_BITS-1:0];
  assign d_id  = ram_q[EW-1:KEY_BITS];

  assign rem_match = (req == spq_pkg::REQ_EXTRACT) || (d_id == nid);
  // front entry only yields to a strictly larger key; the rest yield to equal or larger
  assign ins_shift = (lag == '0) ? (d_key < nkey) : (d_key <= nkey);
  assign ins_n     = (state == S_REM) ? (count - CW'(found)) : count;
  assign out_free  = !out_valid || m_tready;

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = lag;
    ram_wr_data = ram_q;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr[AW-1:0];
    case (state)
      S_REM: begin
        ram_rd_en = ptr < count;
        // entries behind the removed one move down a place
        if (lag_ok && found) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = lag - AW'(1);
        end
      end
      S_INS: begin
        ram_rd_en = issue_ok;
        if (pend0) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = '0;
          ram_wr_data = {nid, nkey};
        end else if (lag_ok) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = lag + AW'(1);
          if (!ins_shift) begin
            ram_wr_data = {nid, nkey};
          end
        end
      end
      S_FRONT: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      lag_ok    <= 1'b0;
      issue_ok  <= 1'b0;
      found     <= 1'b0;
      pend0     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a new result in S_DONE takes over the register in the same cycle
      if (out_valid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req    <= s_tuser;
            nid    <= s_tdata[ID_BITS-1:0];
            nkey   <= s_tdata[EW-1:ID_BITS];
            xid    <= '0;
            xkey   <= '0;
            found  <= 1'b0;
            lag_ok <= 1'b0;
            case (s_tuser)
              spq_pkg::REQ_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  status <= spq_pkg::STAT_FULL;
                  pend0  <= 1'b0;
                  ptr    <= '0;
                  state  <= S_FRONT;
                end else if (count == '0) begin
                  status   <= spq_pkg::STAT_OK;
                  pend0    <= 1'b1;
                  ptr      <= '0;
                  issue_ok <= 1'b0;
                  state    <= S_INS;
                end else begin
                  status   <= spq_pkg::STAT_OK;
                  pend0    <= 1'b0;
                  ptr      <= count - CW'(1);
                  issue_ok <= 1'b1;
                  state    <= S_INS;
                end
              end
              spq_pkg::REQ_EXTRACT, spq_pkg::REQ_CHANGE: begin
                pend0 <= 1'b0;
                ptr   <= '0;
                if (count == '0) begin
                  status <= spq_pkg::STAT_EMPTY;
                  state  <= S_DONE;
                end else begin
                  status <= spq_pkg::STAT_OK;
                  state  <= S_REM;
                end
              end
              default: begin
                status <= spq_pkg::STAT_OK;
                pend0  <= 1'b0;
                ptr    <= '0;
                state  <= S_FRONT;
              end
            endcase
          end
        end
        S_REM: begin
          if (lag_ok && !found && rem_match) begin
            found <= 1'b1;
            if (req == spq_pkg::REQ_EXTRACT) begin
              xid  <= d_id;
              xkey <= d_key;
            end
          end
          if (ptr < count) begin
            ptr    <= ptr + CW'(1);
            lag    <= ptr[AW-1:0];
            lag_ok <= 1'b1;
          end else begin
            lag_ok <= 1'b0;
          end
          // pass over: all reads issued and the last one consumed
          if (!lag_ok && (ptr >= count)) begin
            count <= ins_n;
            if (req == spq_pkg::REQ_EXTRACT) begin
              state <= S_FRONT;
            end else if (ins_n == CW'(CAPACITY)) begin
              status <= spq_pkg::STAT_FULL;
              state  <= S_FRONT;
            end else if (ins_n == '0) begin
              pend0    <= 1'b1;
              issue_ok <= 1'b0;
              state    <= S_INS;
            end else begin
              ptr      <= ins_n - CW'(1);
              issue_ok <= 1'b1;
              state    <= S_INS;
            end
          end
        end
        S_INS: begin
          // scan downward from the tail, moving entries up until the slot is found
          if (issue_ok) begin
            lag    <= ptr[AW-1:0];
            lag_ok <= 1'b1;
            if (ptr == '0) begin
              issue_ok <= 1'b0;
            end else begin
              ptr <= ptr - CW'(1);
            end
          end else begin
            lag_ok <= 1'b0;
          end
          if (pend0) begin
            pend0 <= 1'b0;
            count <= count + CW'(1);
            state <= S_FRONT;
          end else if (lag_ok) begin
            if (ins_shift && (lag == '0)) begin
              pend0 <= 1'b1;
            end else if (!ins_shift) begin
              count <= count + CW'(1);
              state <= S_FRONT;
            end
          end
        end
        S_FRONT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_status  <= status;
            out_id      <= xid;
            out_key     <= xkey;
            front_id    <= (count == '0) ? '0 : d_id;
            front_key   <= (count == '0) ? '0 : d_key;
            entry_count <= count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = OUT_W'({entry_count, front_key, front_id, out_key, out_id});

endmodule

@@ rtl/core/spq_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module spq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ tb/sv/tb_sorted_priority_queue_core.sv @@
// Self-checking testbench for the sorted-list priority queue core, with a predictor and random idling.
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IN_W  = 24;
  localparam int OUT_W = 56;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    logic [1:0]          status;
    logic [ID_BITS-1:0]  out_id;
    logic [KEY_BITS-1:0] out_key;
    logic [ID_BITS-1:0]  front_id;
    logic [KEY_BITS-1:0] front_key;
    logic [4:0]          count;
  } queue_result_t;

  typedef struct packed {
    logic [1:0]          req;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
    logic                typed;
    queue_result_t       want;
  } stim_row_t;

  localparam queue_result_t NO_RESULT = '0;

  // typed rows carry their result; the rest take theirs from the predictor
  localparam stim_row_t DIRECTED [0:26] = '{
    '{REQ_EXTRACT, 8'h00, 16'h0000, 1'b1, '{STAT_EMPTY, 8'h00, 16'h0000, 8'h00, 16'h0000, 5'd0}},
    '{REQ_CHANGE,  8'h12, 16'h3456, 1'b1, '{STAT_EMPTY, 8'h00, 16'h0000, 8'h00, 16'h0000, 5'd0}},
    '{REQ_UNUSED,  8'hff, 16'hffff, 1'b1, '{STAT_OK,    8'h00, 16'h0000, 8'h00, 16'h0000, 5'd0}},
    '{REQ_INSERT,  8'hff, 16'hffff, 1'b1, '{STAT_OK,    8'h00, 16'h0000, 8'hff, 16'hffff, 5'd1}},
    '{REQ_EXTRACT, 8'h00, 16'h0000, 1'b1, '{STAT_OK,    8'hff, 16'hffff, 8'h00, 16'h0000, 5'd0}},
    '{REQ_INSERT,  8'h00, 16'h0000, 1'b1, '{STAT_OK,    8'h00, 16'h0000, 8'h00, 16'h0000, 5'd1}},
    '{REQ_INSERT,  8'h01, 16'h0000, 1'b1, '{STAT_OK,    8'h00, 16'h0000, 8'h00, 16'h0000, 5'd2}},
    '{REQ_INSERT,  8'h02, 16'h8000, 1'b1, '{STAT_OK,    8'h00, 16'h0000, 8'h02, 16'h8000, 5'd3}},
    '{REQ_INSERT,  8'h03, 16'h8000, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h04, 16'h4000, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h05, 16'h4000, 1'b0, NO_RESULT},
    '{REQ_CHANGE,  8'h01, 16'hffff, 1'b0, NO_RESULT},
    '{REQ_CHANGE,  8'h77, 16'h1234, 1'b0, NO_RESULT},
    '{REQ_UNUSED,  8'h03, 16'h0000, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h80, 16'hffff, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h55, 16'h5555, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'haa, 16'haaaa, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h0f, 16'h0000, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'hf0, 16'h4000, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h33, 16'h0001, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'hcc, 16'hfffe, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h7f, 16'h8000, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'hfe, 16'h7fff, 1'b0, NO_RESULT},
    '{REQ_INSERT,  8'h99, 16'h2222, 1'b0, NO_RESULT},
    '{REQ_CHANGE,  8'h66, 16'h6666, 1'b0, NO_RESULT},
    '{REQ_CHANGE,  8'h05, 16'haaaa, 1'b0, NO_RESULT},
    '{REQ_EXTRACT, 8'h00, 16'h0000, 1'b0, NO_RESULT}
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;   // item_id, item_key
  logic [1:0]      s_tuser = '0;   // req_type
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;       // out_id, out_key, front_id, front_key, entry_count
  logic [1:0]      m_tuser;        // status

  // side-band for the item on the bus: whether its result is typed in the table
  logic            item_typed = 1'b0;
  queue_result_t   item_want = '0;
  logic            calm = 1'b0;

  sorted_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predictor state: entries sorted by key, largest first
  logic [ID_BITS-1:0]  queue_ids  [CAPACITY];
  logic [KEY_BITS-1:0] queue_keys [CAPACITY];
  int                  queue_fill = 0;

  queue_result_t expected_results [$];
  int            mismatch_count = 0;
  int            result_index = 0;

  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < queue_fill; i++) begin
      queue_ids[i]  = queue_ids[i + 1];
      queue_keys[i] = queue_keys[i + 1];
    end
    queue_fill--;
  endfunction

  function automatic bit place_entry(logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key);
    int pos;
    int i;
    if (queue_fill >= CAPACITY) return 1'b0;
    // never ahead of the front entry unless strictly larger
    if (queue_fill == 0 || queue_keys[0] < key) begin
      pos = 0;
    end else begin
      pos = 1;
      while (pos < queue_fill && key < queue_keys[pos]) pos++;
    end
    for (i = queue_fill; i > pos; i--) begin
      queue_ids[i]  = queue_ids[i - 1];
      queue_keys[i] = queue_keys[i - 1];
    end
    queue_ids[pos]  = id;
    queue_keys[pos] = key;
    queue_fill++;
    return 1'b1;
  endfunction

  function automatic queue_result_t predict_request(logic [1:0] req, logic [ID_BITS-1:0] id,
                                                    logic [KEY_BITS-1:0] key);
    queue_result_t r;
    int i;
    r = NO_RESULT;
    r.status = STAT_OK;
    case (req)
      REQ_INSERT: begin
        if (!place_entry(id, key)) r.status = STAT_FULL;
      end
      REQ_EXTRACT: begin
        if (queue_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.out_id  = queue_ids[0];
          r.out_key = queue_keys[0];
          drop_entry(0);
        end
      end
      REQ_CHANGE: begin
        if (queue_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (i = 0; i < queue_fill; i++) begin
            if (queue_ids[i] == id) begin
              drop_entry(i);
              break;
            end
          end
          if (!place_entry(id, key)) r.status = STAT_FULL;
        end
      end
      default: ;
    endcase
    if (queue_fill != 0) begin
      r.front_id  = queue_ids[0];
      r.front_key = queue_keys[0];
    end
    r.count = 5'(queue_fill);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("tb: mismatch in %s at result %0d: got %0h, expected %0h",
             field, result_index, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(queue_result_t got, queue_result_t want);
    if (got.status !== want.status)       report_mismatch("status", got.status, want.status);
    if (got.out_id !== want.out_id)       report_mismatch("out_id", got.out_id, want.out_id);
    if (got.out_key !== want.out_key)     report_mismatch("out_key", got.out_key, want.out_key);
    if (got.front_id !== want.front_id)   report_mismatch("front_id", got.front_id, want.front_id);
    if (got.front_key !== want.front_key) report_mismatch("front_key", got.front_key, want.front_key);
    if (got.count !== want.count)         report_mismatch("entry_count", got.count, want.count);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 16);
  end

  // accepted requests go through the predictor first, then any finished transfer is checked
  queue_result_t predicted;
  queue_result_t seen;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predicted = predict_request(s_tuser, s_tdata[ID_BITS-1:0],
                                    s_tdata[ID_BITS +: KEY_BITS]);
        expected_results.push_back(item_typed ? item_want : predicted);
      end
      if (m_tvalid && m_tready) begin
        seen.status    = m_tuser;
        seen.out_id    = m_tdata[7:0];
        seen.out_key   = m_tdata[23:8];
        seen.front_id  = m_tdata[31:24];
        seen.front_key = m_tdata[47:32];
        seen.count     = m_tdata[52:48];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", m_tdata, 0);
        end else begin
          check_result(seen, expected_results.pop_front());
        end
        result_index++;
      end
    end
  end

  task automatic send_item(logic [1:0] req, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key,
                           logic typed, queue_result_t want);
    s_tvalid   <= 1'b1;
    s_tuser    <= req;
    s_tdata    <= {key, id};
    item_typed <= typed;
    item_want  <= want;
    do @(posedge clk); while (!s_tready);
    if (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  initial begin
    int i;
    int sent;
    int n;
    int bias;
    int r;
    int recent_n;
    int recent_wr;
    logic [1:0]          req;
    logic [ID_BITS-1:0]  id;
    logic [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]  recent_ids [16];

    sent = 0;
    n = 0;
    bias = 50;
    recent_n = 0;
    recent_wr = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(DIRECTED); i++)
      send_item(DIRECTED[i].req, DIRECTED[i].id, DIRECTED[i].key,
                DIRECTED[i].typed, DIRECTED[i].want);

    while (sent < RANDOM_ITEMS) begin
      // insert bias swings per epoch so the queue both fills up and drains
      if (n % 64 == 0) begin
        case ($urandom_range(2))
          0:       bias = 25;
          1:       bias = 50;
          default: bias = 85;
        endcase
      end
      calm <= (sent >= 700 && sent < 1000);
      r = $urandom_range(99);
      if (r < 3) begin
        req = REQ_UNUSED;
      end else begin
        r = $urandom_range(99);
        if (r < bias)                         req = REQ_INSERT;
        else if (r < bias + (100 - bias) / 2) req = REQ_EXTRACT;
        else                                  req = REQ_CHANGE;
      end
      if ($urandom_range(3) == 0) id = ID_BITS'($urandom_range(255));
      else                        id = ID_BITS'($urandom_range(15));
      if (req == REQ_CHANGE && recent_n > 0 && $urandom_range(9) < 7)
        id = recent_ids[$urandom_range(recent_n - 1)];
      case ($urandom_range(3))
        0:       key = KEY_BITS'($urandom_range(7));
        1:       key = 16'hffff - 16'($urandom_range(3));
        default: key = KEY_BITS'($urandom_range(65535));
      endcase
      if (req == REQ_INSERT || req == REQ_CHANGE) begin
        recent_ids[recent_wr] = id;
        recent_wr = (recent_wr + 1) % 16;
        if (recent_n < 16) recent_n++;
      end
      send_item(req, id, key, 1'b0, NO_RESULT);
      if (req != REQ_UNUSED) sent++;
      n++;
    end
    s_tvalid <= 1'b0;
    calm <= 1'b0;

    // wait for the clock so the last accepted item is in the expected list
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("missing transfers", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue_core.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/sorted_priority_queue_core.sv
tb/sv/tb_sorted_priority_queue_core.sv
